FILE: src/tcts_pkg.sv
// Shared types, constants and helpers for the three-class teller scheduler.
// Used by tcts_pick, the top level and the checker. No dependencies.
`default_nettype none

package tcts_pkg;

  localparam int MAX_SERVERS = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_CLASSES = 3;

  // Fixed field widths
  localparam int CLS_W     = 2;
  localparam int ID_W      = 16;
  localparam int STATUS_W  = 2;
  localparam int SRV_IDX_W = 4;
  localparam int FREED_W   = 5;
  localparam int SC_W      = 5;   // server_count register
  localparam int LIM_W     = 4;   // fairness_limit register and streak counter
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  // Derived widths
  localparam int SRV_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int QPW    = $clog2(QUEUE_DEPTH);
  localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_D  = NUM_CLASSES * QUEUE_DEPTH;
  localparam int MEM_AW = $clog2(MEM_D);

  // Reset values of the configuration registers
  localparam logic [SC_W-1:0]  SERVER_COUNT_RST   = SC_W'(9);
  localparam logic [LIM_W-1:0] FAIRNESS_LIMIT_RST = LIM_W'(5);

  // Register index (paddr bit 2)
  localparam logic REG_SERVER_COUNT   = 1'b0;
  localparam logic REG_FAIRNESS_LIMIT = 1'b1;

  // Input function codes
  localparam logic FUNC_ARRIVAL = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  // Class codes
  localparam logic [CLS_W-1:0] CLASS_HIGH = 2'd0;
  localparam logic [CLS_W-1:0] CLASS_MID  = 2'd1;
  localparam logic [CLS_W-1:0] CLASS_LOW  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd3;

  typedef struct packed {
    logic             ok;
    logic [SRV_W-1:0] idx;
  } pick_t;

  // Flat address of entry ptr of class cls in the shared id memory
  function automatic logic [MEM_AW-1:0] fifo_addr(input logic [CLS_W-1:0] cls,
                                                   input logic [QPW-1:0]   ptr);
    logic [MEM_AW-1:0] base;
    base = MEM_AW'(cls) * MEM_AW'(QUEUE_DEPTH);
    return base + MEM_AW'(ptr);
  endfunction

endpackage

`default_nettype wire

FILE: src/three_class_teller_scheduler_top.sv
// Three-class teller scheduler, top level: command port, APB config, FIFOs, sequencer.
// Depends on tcts_pkg and tcts_pick.
`default_nettype none

// Strict-priority scheduler for three request classes (0 highest, 2 lowest)
// over up to 16 servers, with a starvation guard for class 2. A transaction is
// taken when start is high and busy is low. An arrival (func 0) keeps busy high
// in its S_ARR state; its one result is on the ports in the cycle right after
// that. A tick (func 1) keeps busy high through S_FREE, which frees every active
// server and counts those that were busy, then S_TRY, which takes the classes in
// turn while the shared picker finds the lowest free server and applies the
// guard for each, and last the closing state S_FIN. A tick
// gives one result per head placed (class order, at most three) or a single
// "none placed" result; last marks the final one. Results appear on the
// result ports for exactly one cycle with result_valid high; the receiver
// cannot stall them, so they must be captured when shown. Queued ids live in
// one 48-entry memory (16 per class) with a registered read port; its
// contents are undefined until written and need no clearing after reset.
// Config registers: server_count at 0x0, fairness_limit at 0x4; write only
// while the block is idle.

module three_class_teller_scheduler_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // command channel
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              func,
  input  wire logic [tcts_pkg::CLS_W-1:0]        request_class,
  input  wire logic [tcts_pkg::ID_W-1:0]         request_id,
  // result channel
  output logic                                   result_valid,
  output logic [tcts_pkg::STATUS_W-1:0]          status,
  output logic [tcts_pkg::SRV_IDX_W-1:0]         server_index,
  output logic [tcts_pkg::ID_W-1:0]              placed_id,
  output logic [tcts_pkg::CLS_W-1:0]             placed_class,
  output logic [tcts_pkg::FREED_W-1:0]           freed_count,
  output logic                                   last,
  // APB config port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tcts_pkg::APB_AW-1:0]       paddr,
  input  wire logic [tcts_pkg::APB_DW-1:0]       pwdata,
  output logic [tcts_pkg::APB_DW-1:0]            prdata,
  output logic                                   pready
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ARR  = 5'b00010,
    S_FREE = 5'b00100,
    S_TRY  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state;

  // config registers
  logic [tcts_pkg::SC_W-1:0]  server_count;
  logic [tcts_pkg::LIM_W-1:0] fairness_limit;

  // scheduler state
  logic [tcts_pkg::MAX_SERVERS-1:0] server_busy;
  logic [tcts_pkg::QPW-1:0]         fifo_head  [tcts_pkg::NUM_CLASSES];
  logic [tcts_pkg::QCW-1:0]         fifo_count [tcts_pkg::NUM_CLASSES];
  logic [tcts_pkg::LIM_W-1:0]       streak;

  // latched transaction
  logic [tcts_pkg::CLS_W-1:0]    op_cls;
  logic [tcts_pkg::ID_W-1:0]     op_id;

  // tick working registers
  logic [tcts_pkg::CLS_W-1:0]    try_cls;
  logic [tcts_pkg::FREED_W-1:0]  freed_cnt;
  logic                          pend_valid;
  logic [tcts_pkg::SRV_W-1:0]    pend_srv;
  logic [tcts_pkg::CLS_W-1:0]    pend_cls;

  // id memory
  logic [tcts_pkg::ID_W-1:0]     fifo_mem [tcts_pkg::MEM_D];
  logic [tcts_pkg::ID_W-1:0]     rd_data;
  logic                          mem_wr;
  logic                          mem_rd;

  logic                          accept;
  logic                          cfg_wr;
  logic [tcts_pkg::SC_W-1:0]     active_n;
  logic [tcts_pkg::MAX_SERVERS-1:0] active_mask;
  logic [tcts_pkg::FREED_W-1:0]  freed_sum;

  logic                          cls_ok;
  logic [tcts_pkg::CLS_W-1:0]    cur_cls;
  logic [tcts_pkg::QCW-1:0]      cur_cnt;
  logic [tcts_pkg::QPW-1:0]      cur_head;
  logic [tcts_pkg::QPW-1:0]      cur_tail;
  logic [tcts_pkg::QPW-1:0]      head_next;
  logic [tcts_pkg::QCW:0]        tail_sum;
  logic                          arr_place;
  logic                          arr_drop;
  logic                          try_place;
  logic                          do_occupy;
  logic [tcts_pkg::LIM_W-1:0]    streak_next;
  tcts_pkg::pick_t               pick;

  // result staging
  logic                              res_emit;
  logic [tcts_pkg::STATUS_W-1:0]     res_status;
  logic [tcts_pkg::SRV_IDX_W-1:0]    res_srv;
  logic [tcts_pkg::ID_W-1:0]         res_id;
  logic [tcts_pkg::CLS_W-1:0]        res_cls;
  logic [tcts_pkg::FREED_W-1:0]      res_freed;
  logic                              res_last;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      tcts_pkg::REG_SERVER_COUNT: prdata = tcts_pkg::APB_DW'(server_count);
      default:                    prdata = tcts_pkg::APB_DW'(fairness_limit);
    endcase
  end

  // Active servers: count saturates at the number built
  assign active_n = (server_count > tcts_pkg::SC_W'(tcts_pkg::MAX_SERVERS)) ?
                    tcts_pkg::SC_W'(tcts_pkg::MAX_SERVERS) : server_count;

  always_comb begin
    for (int i = 0; i < tcts_pkg::MAX_SERVERS; i++) begin
      active_mask[i] = (i < int'(active_n));
    end
  end

  always_comb begin
    freed_sum = '0;
    for (int i = 0; i < tcts_pkg::MAX_SERVERS; i++) begin
      freed_sum = freed_sum + tcts_pkg::FREED_W'(server_busy[i] & active_mask[i]);
    end
  end

  // Class under work: the arriving class, or the class the tick is trying.
  // An invalid arriving class is dropped and only selects class 0 here.
  assign cls_ok  = (op_cls < tcts_pkg::CLS_W'(tcts_pkg::NUM_CLASSES));
  assign cur_cls = (state == S_TRY) ? try_cls : (cls_ok ? op_cls : tcts_pkg::CLASS_HIGH);
  assign cur_cnt  = fifo_count[cur_cls];
  assign cur_head = fifo_head[cur_cls];

  assign tail_sum = (tcts_pkg::QCW+1)'(cur_head) + (tcts_pkg::QCW+1)'(cur_cnt);
  assign cur_tail = (tail_sum >= (tcts_pkg::QCW+1)'(tcts_pkg::QUEUE_DEPTH)) ?
                    tcts_pkg::QPW'(tail_sum - (tcts_pkg::QCW+1)'(tcts_pkg::QUEUE_DEPTH)) :
                    tcts_pkg::QPW'(tail_sum);
  assign head_next = (cur_head == tcts_pkg::QPW'(tcts_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : cur_head + 1'b1;

  tcts_pick u_pick (
    .server_busy (server_busy),
    .active_mask (active_mask),
    .streak      (streak),
    .limit       (fairness_limit),
    .cls         (cur_cls),
    .low_waiting (fifo_count[tcts_pkg::CLASS_LOW] != '0),
    .pick        (pick)
  );

  assign arr_place = cls_ok && (cur_cnt == '0) && pick.ok;
  assign arr_drop  = !cls_ok || (cur_cnt >= tcts_pkg::QCW'(tcts_pkg::QUEUE_DEPTH));
  assign try_place = (cur_cnt != '0) && pick.ok;
  assign do_occupy = ((state == S_ARR) && arr_place) || ((state == S_TRY) && try_place);
  assign mem_wr    = (state == S_ARR) && !arr_place && !arr_drop;
  assign mem_rd    = (state == S_TRY) && try_place;

  // Streak: class 2 clears it, class 0/1 counts up to the limit
  always_comb begin
    if (cur_cls == tcts_pkg::CLASS_LOW) begin
      streak_next = '0;
    end else if (streak < fairness_limit) begin
      streak_next = streak + 1'b1;
    end else begin
      streak_next = fairness_limit;
    end
  end

  // Result staging. A tick result is held in pend_* until we know whether
  // another class places after it, so last can be set on the final one.
  always_comb begin
    res_emit   = 1'b0;
    res_status = tcts_pkg::ST_NONE;
    res_srv    = '0;
    res_id     = '0;
    res_cls    = '0;
    res_freed  = '0;
    res_last   = 1'b0;
    case (state)
      S_ARR: begin
        res_emit = 1'b1;
        res_id   = op_id;
        res_cls  = op_cls;
        res_last = 1'b1;
        if (arr_place) begin
          res_status = tcts_pkg::ST_PLACED;
          res_srv    = tcts_pkg::SRV_IDX_W'(pick.idx);
        end else if (arr_drop) begin
          res_status = tcts_pkg::ST_DROPPED;
        end else begin
          res_status = tcts_pkg::ST_QUEUED;
        end
      end
      S_TRY: begin
        res_emit   = try_place && pend_valid;
        res_status = tcts_pkg::ST_PLACED;
        res_srv    = tcts_pkg::SRV_IDX_W'(pend_srv);
        res_id     = rd_data;
        res_cls    = pend_cls;
        res_freed  = freed_cnt;
      end
      S_FIN: begin
        res_emit  = 1'b1;
        res_freed = freed_cnt;
        res_last  = 1'b1;
        if (pend_valid) begin
          res_status = tcts_pkg::ST_PLACED;
          res_srv    = tcts_pkg::SRV_IDX_W'(pend_srv);
          res_id     = rd_data;
          res_cls    = pend_cls;
        end
      end
      default: begin
        res_emit = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      server_count   <= tcts_pkg::SERVER_COUNT_RST;
      fairness_limit <= tcts_pkg::FAIRNESS_LIMIT_RST;
      server_busy    <= '0;
      streak         <= '0;
      result_valid   <= 1'b0;
      pend_valid     <= 1'b0;
      try_cls        <= tcts_pkg::CLASS_HIGH;
      for (int c = 0; c < tcts_pkg::NUM_CLASSES; c++) begin
        fifo_head[c]  <= '0;
        fifo_count[c] <= '0;
      end
    end else begin
      result_valid <= res_emit;

      if (cfg_wr) begin
        case (paddr[2])
          tcts_pkg::REG_SERVER_COUNT: server_count <= pwdata[tcts_pkg::SC_W-1:0];
          default:                    fairness_limit <= pwdata[tcts_pkg::LIM_W-1:0];
        endcase
      end

      if (do_occupy) begin
        server_busy[pick.idx] <= 1'b1;
        streak                <= streak_next;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (func == tcts_pkg::FUNC_TICK) ? S_FREE : S_ARR;
          end
        end
        S_ARR: begin
          if (mem_wr) begin
            fifo_count[cur_cls] <= cur_cnt + 1'b1;
          end
          state <= S_IDLE;
        end
        S_FREE: begin
          server_busy <= server_busy & ~active_mask;
          try_cls     <= tcts_pkg::CLASS_HIGH;
          pend_valid  <= 1'b0;
          state       <= S_TRY;
        end
        S_TRY: begin
          if (try_place) begin
            fifo_head[cur_cls]  <= head_next;
            fifo_count[cur_cls] <= cur_cnt - 1'b1;
            pend_valid          <= 1'b1;
          end
          try_cls <= try_cls + 1'b1;
          if (try_cls == tcts_pkg::CLASS_LOW) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_cls  <= request_class;
      op_id   <= request_id;
    end
    if (state == S_FREE) begin
      freed_cnt <= freed_sum;
    end
    if (mem_rd) begin
      pend_srv <= pick.idx;
      pend_cls <= cur_cls;
    end
    if (res_emit) begin
      status       <= res_status;
      server_index <= res_srv;
      placed_id    <= res_id;
      placed_class <= res_cls;
      freed_count  <= res_freed;
      last         <= res_last;
    end
  end

  // Id memory: one write port (queue tail), one registered read port (head)
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      fifo_mem[tcts_pkg::fifo_addr(cur_cls, cur_tail)] <= op_id;
    end
    if (mem_rd) begin
      rd_data <= fifo_mem[tcts_pkg::fifo_addr(cur_cls, cur_head)];
    end
  end

endmodule

`default_nettype wire

FILE: src/tcts_pick.sv
// Shared server picker: lowest free active server plus the starvation guard.
// Depends on tcts_pkg.
`default_nettype none

module tcts_pick (
  input  wire logic [tcts_pkg::MAX_SERVERS-1:0] server_busy,
  input  wire logic [tcts_pkg::MAX_SERVERS-1:0] active_mask,
  input  wire logic [tcts_pkg::LIM_W-1:0]       streak,
  input  wire logic [tcts_pkg::LIM_W-1:0]       limit,
  input  wire logic [tcts_pkg::CLS_W-1:0]       cls,
  input  wire logic                             low_waiting,
  output tcts_pkg::pick_t                       pick
);

  logic                       found;
  logic [tcts_pkg::SRV_W-1:0] idx;
  logic                       blocked;

  // Priority encoder, lowest index wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = tcts_pkg::MAX_SERVERS - 1; i >= 0; i--) begin
      if (active_mask[i] && !server_busy[i]) begin
        found = 1'b1;
        idx   = tcts_pkg::SRV_W'(i);
      end
    end
  end

  assign blocked  = (streak >= limit) && (cls < tcts_pkg::CLASS_LOW) && low_waiting;
  assign pick.ok  = found && !blocked;
  assign pick.idx = idx;

endmodule

`default_nettype wire

FILE: src/tcts_checker.sv
// Port-level checker for the three-class teller scheduler, bound to the top.
// Depends on tcts_pkg and three_class_teller_scheduler_top.
`default_nettype none

module tcts_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          result_valid,
  input wire logic [tcts_pkg::STATUS_W-1:0] status,
  input wire logic [tcts_pkg::FREED_W-1:0]  freed_count,
  input wire logic                          last
);

  // An accepted transaction always holds the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after accepted transaction");

  // "none placed" is always the only and final result of a tick: it must carry last
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status == tcts_pkg::ST_NONE)) |-> last)
    else $error("none-placed result without last");

  // Queued and dropped results come from arrivals: single result, no freed servers
  a_arrival_shape: assert property (@(posedge clk) disable iff (rst)
    (result_valid && ((status == tcts_pkg::ST_QUEUED) || (status == tcts_pkg::ST_DROPPED)))
      |-> (last && (freed_count == '0)))
    else $error("queued/dropped result malformed");

  // A final result is never directly followed by another result
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |=> !result_valid)
    else $error("result right after final result");

endmodule

bind three_class_teller_scheduler_top tcts_checker u_tcts_checker (.*);

`default_nettype wire
